### rtl/rhpt_pkg.sv
`timescale 1ns / 1ps
package rhpt_pkg;

  localparam int unsigned HW    = 31;
  localparam int unsigned CHW   = 8;
  localparam int unsigned IDXW  = 10;
  localparam int unsigned STEPW = 5;

  localparam logic [HW-1:0] BASE_RST = 31'd131;
  localparam logic [HW-1:0] MOD_RST  = 31'd1000000007;
  localparam logic [HW-1:0] MOD_MIN  = 31'd2;

  localparam logic [STEPW-1:0] RED_STEPS_WORD = STEPW'(HW);
  localparam logic [STEPW-1:0] RED_STEPS_CHAR = STEPW'(CHW);
  localparam logic [STEPW-1:0] SUB_STEPS      = STEPW'(1);

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_REMOVE,
    OP_QUERY,
    OP_ENCODE
  } op_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_RANGE
  } status_e;

  typedef enum logic [0:0] {
    CFG_BASE,
    CFG_MOD
  } cfg_e;

  typedef enum logic [1:0] {
    MU_MUL,
    MU_RED,
    MU_SUB
  } mu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE,
    S_BASE_W,
    S_DISP,
    S_AP_RD,
    S_CRED,
    S_CRED_W,
    S_MUL_H,
    S_MUL_P,
    S_RM,
    S_RM_W,
    S_Q_RD1,
    S_Q_RD2,
    S_Q_MUL,
    S_Q_SUB,
    S_OUT
  } seq_e;

  typedef struct packed {
    logic             go;
    mu_op_e           op;
    logic [STEPW-1:0] steps;
  } mu_req_t;

  typedef struct packed {
    logic          done;
    logic [HW-1:0] res;
  } mu_rsp_t;

endpackage

### rtl/rhpt_ram.sv
`timescale 1ns / 1ps
module rhpt_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/rhpt_modunit.sv
`timescale 1ns / 1ps
module rhpt_modunit import rhpt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mu_req_t       req_i,
  input  logic [HW-1:0] x_i,
  input  logic [HW-1:0] y_i,
  input  logic [HW-1:0] z_i,
  input  logic [HW-1:0] mod_i,
  output mu_rsp_t       rsp_o
);

  logic             busy_q, busy_d;
  mu_op_e           op_q, op_d;
  logic [HW-1:0]    a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [STEPW-1:0] cnt_q, cnt_d;
  logic             finish;
  logic [HW:0]      mod_x, sum, sum_red, dbl, dbl_red, shl, shl_red, diff, diff_fix;

  always_comb begin
    mod_x    = {1'b0, mod_i};
    sum      = {1'b0, acc_q} + {1'b0, b_q};
    sum_red  = (sum >= mod_x) ? sum - mod_x : sum;
    dbl      = {b_q, 1'b0};
    dbl_red  = (dbl >= mod_x) ? dbl - mod_x : dbl;
    shl      = {acc_q, a_q[HW-1]};
    shl_red  = (shl >= mod_x) ? shl - mod_x : shl;
    diff     = {1'b0, a_q} - {1'b0, b_q};
    diff_fix = diff + mod_x;
    case (op_q)
      MU_MUL:  finish = (a_q == '0);
      default: finish = (cnt_q == '0);
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    if (req_i.go) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      a_d    = x_i;
      b_d    = y_i;
      acc_d  = z_i;
      cnt_d  = req_i.steps;
    end else if (busy_q) begin
      if (finish) begin
        busy_d = 1'b0;
      end else begin
        case (op_q)
          MU_MUL: begin
            if (a_q[0]) begin
              acc_d = sum_red[HW-1:0];
            end
            b_d = dbl_red[HW-1:0];
            a_d = a_q >> 1;
          end
          MU_RED: begin
            acc_d = shl_red[HW-1:0];
            a_d   = a_q << 1;
            cnt_d = cnt_q - STEPW'(1);
          end
          MU_SUB: begin
            acc_d = diff[HW] ? diff_fix[HW-1:0] : diff[HW-1:0];
            cnt_d = cnt_q - STEPW'(1);
          end
          default: begin
            busy_d = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= MU_MUL;
    end else begin
      busy_q <= busy_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    cnt_q <= cnt_d;
  end

  assign rsp_o.done = busy_q && finish;
  assign rsp_o.res  = acc_q;

endmodule

### rtl/rolling_hash_prefix_table.sv
`timescale 1ns / 1ps
// Channel   | Direction | Signals                                          | Handshake
// ----------+-----------+--------------------------------------------------+------------------
// request   | in        | operation_i char_value_i left_index_i            | start && !busy
//           |           | right_index_i encode_start_i                     |
// result    | out       | hash_value_o stored_length_o status_o            | done_o, one cycle
// config    | in        | cfg_idx_i cfg_data_i                             | cfg_we_i
//
// One request at a time; busy is high from acceptance until the done_o cycle ends.
// Modular multiply is bit serial in the shared unit, one multiplier bit per cycle,
// stopping at the last set bit. Append does a char reduce plus two multiplies,
// encode a char reduce plus one multiply, query one multiply and a subtract; remove,
// full append and bad range need no multiply. The first request after reset or a config
// write also reduces the base first. Stores need no clearing after reset; results cannot be stalled.
module rolling_hash_prefix_table import rhpt_pkg::*; #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   operation_i,
  input  logic [CHW-1:0]               char_value_i,
  input  logic [IDXW-1:0]              left_index_i,
  input  logic [IDXW-1:0]              right_index_i,
  input  logic                         encode_start_i,
  output logic                         done_o,
  output logic [HW-1:0]                hash_value_o,
  output logic [$clog2(MAX_LEN+1)-1:0] stored_length_o,
  output logic [1:0]                   status_o,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [HW-1:0]                cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned XW = ((CW > IDXW) ? CW : IDXW) + 1;
  localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

  seq_e          state_q, state_d;
  op_e           op_q, op_d;
  status_e       st_q, st_d;
  logic [CHW-1:0] ch_q, ch_d;
  logic [IDXW-1:0] left_q, left_d, right_q, right_d;
  logic          enc_start_q, enc_start_d;
  logic [HW-1:0] base_q, base_d, mod_q, mod_d, base_red_q, base_red_d;
  logic          base_ok_q, base_ok_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [HW-1:0] enc_q, enc_d, hv_q, hv_d, hi_q, hi_d, pw_q, pw_d, pa_q, pa_d;

  logic          accept, full, empty, left_zero, bad_range;
  logic [XW-1:0] left_x, right_x, fill_x, span_x, leftm1_x, fillm1_x;

  mu_req_t       mu_req;
  mu_rsp_t       mu_rsp;
  logic [HW-1:0] mu_x, mu_y, mu_z;

  logic          pre_we, pre_re, pow_we, pow_re;
  logic [AW-1:0] pre_raddr, pow_raddr, waddr;
  logic [HW-1:0] pre_wdata, pow_wdata, pre_rdata, pow_rdata;

  assign accept    = start && !busy;
  assign left_x    = XW'(left_q);
  assign right_x   = XW'(right_q);
  assign fill_x    = XW'(fill_q);
  assign span_x    = right_x - left_x;
  assign leftm1_x  = left_x - XW'(1);
  assign fillm1_x  = fill_x - XW'(1);
  assign full      = (fill_q == FULL);
  assign empty     = (fill_q == '0);
  assign left_zero = (left_q == '0);
  assign bad_range = (left_q > right_q) || (right_x >= fill_x);
  assign waddr     = fill_x[AW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = base_ok_q ? S_DISP : S_BASE;
      S_BASE:   state_d = S_BASE_W;
      S_BASE_W: if (mu_rsp.done) state_d = S_DISP;
      S_DISP: begin
        case (op_q)
          OP_APPEND: state_d = full ? S_OUT : (empty ? S_CRED : S_AP_RD);
          OP_REMOVE: state_d = empty ? S_OUT : S_RM;
          OP_QUERY:  state_d = bad_range ? S_OUT : S_Q_RD1;
          default:   state_d = S_CRED;
        endcase
      end
      S_AP_RD:  state_d = S_CRED;
      S_CRED:   state_d = S_CRED_W;
      S_CRED_W: if (mu_rsp.done) state_d = S_MUL_H;
      S_MUL_H:  if (mu_rsp.done) state_d = (op_q == OP_APPEND) ? S_MUL_P : S_OUT;
      S_MUL_P:  if (mu_rsp.done) state_d = S_OUT;
      S_RM:     state_d = empty ? S_OUT : S_RM_W;
      S_RM_W:   state_d = S_OUT;
      S_Q_RD1:  state_d = S_Q_RD2;
      S_Q_RD2:  state_d = S_Q_MUL;
      S_Q_MUL:  if (mu_rsp.done) state_d = S_Q_SUB;
      S_Q_SUB:  if (mu_rsp.done) state_d = S_OUT;
      S_OUT:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    st_d        = st_q;
    ch_d        = ch_q;
    left_d      = left_q;
    right_d     = right_q;
    enc_start_d = enc_start_q;
    base_d      = base_q;
    mod_d       = mod_q;
    base_red_d  = base_red_q;
    base_ok_d   = base_ok_q;
    fill_d      = fill_q;
    enc_d       = enc_q;
    hv_d        = hv_q;
    hi_d        = hi_q;
    pw_d        = pw_q;
    pa_d        = pa_q;
    mu_req      = '{go: 1'b0, op: MU_MUL, steps: '0};
    mu_x        = pa_q;
    mu_y        = base_red_q;
    mu_z        = '0;
    pre_we      = 1'b0;
    pow_we      = 1'b0;
    pre_re      = 1'b0;
    pow_re      = 1'b0;
    pre_raddr   = fillm1_x[AW-1:0];
    pow_raddr   = fillm1_x[AW-1:0];
    pre_wdata   = mu_rsp.res;
    pow_wdata   = mu_rsp.res;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d        = op_e'(operation_i);
          ch_d        = char_value_i;
          left_d      = left_index_i;
          right_d     = right_index_i;
          enc_start_d = encode_start_i;
        end
      end
      S_BASE: begin
        mu_req = '{go: 1'b1, op: MU_RED, steps: RED_STEPS_WORD};
        mu_x   = base_q;
      end
      S_BASE_W: begin
        if (mu_rsp.done) begin
          base_red_d = mu_rsp.res;
          base_ok_d  = 1'b1;
        end
      end
      S_DISP: begin
        st_d = ST_OK;
        hv_d = '0;
        case (op_q)
          OP_APPEND: begin
            if (full) begin
              st_d = ST_FULL;
            end else if (empty) begin
              pa_d = '0;
              pw_d = HW'(1);
            end else begin
              pre_re = 1'b1;
              pow_re = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (empty) begin
              st_d = ST_EMPTY;
            end else begin
              fill_d = fill_q - CW'(1);
            end
          end
          OP_QUERY: begin
            if (bad_range) begin
              st_d = ST_RANGE;
            end else begin
              pre_re    = 1'b1;
              pow_re    = 1'b1;
              pre_raddr = right_x[AW-1:0];
              pow_raddr = span_x[AW-1:0];
            end
          end
          default: begin
            pa_d = enc_start_q ? '0 : enc_q;
          end
        endcase
      end
      S_AP_RD: begin
        pa_d = pre_rdata;
        pw_d = pow_rdata;
      end
      S_CRED: begin
        mu_req = '{go: 1'b1, op: MU_RED, steps: RED_STEPS_CHAR};
        mu_x   = {ch_q, (HW - CHW)'(0)};
      end
      S_CRED_W: begin
        if (mu_rsp.done) begin
          mu_req = '{go: 1'b1, op: MU_MUL, steps: '0};
          mu_x   = pa_q;
          mu_y   = base_red_q;
          mu_z   = mu_rsp.res;
        end
      end
      S_MUL_H: begin
        if (mu_rsp.done) begin
          hv_d = mu_rsp.res;
          if (op_q == OP_APPEND) begin
            pre_we = 1'b1;
            mu_req = '{go: 1'b1, op: MU_MUL, steps: '0};
            mu_x   = pw_q;
            mu_y   = base_red_q;
            mu_z   = '0;
          end else begin
            enc_d = mu_rsp.res;
          end
        end
      end
      S_MUL_P: begin
        if (mu_rsp.done) begin
          pow_we = 1'b1;
          fill_d = fill_q + CW'(1);
        end
      end
      S_RM: begin
        pre_re = !empty;
      end
      S_RM_W: begin
        hv_d = pre_rdata;
      end
      S_Q_RD1: begin
        hi_d      = pre_rdata;
        pw_d      = pow_rdata;
        pre_re    = !left_zero;
        pre_raddr = leftm1_x[AW-1:0];
      end
      S_Q_RD2: begin
        mu_req = '{go: 1'b1, op: MU_MUL, steps: '0};
        mu_x   = left_zero ? '0 : pre_rdata;
        mu_y   = pw_q;
        mu_z   = '0;
      end
      S_Q_MUL: begin
        if (mu_rsp.done) begin
          mu_req = '{go: 1'b1, op: MU_SUB, steps: SUB_STEPS};
          mu_x   = hi_q;
          mu_y   = mu_rsp.res;
        end
      end
      S_Q_SUB: begin
        if (mu_rsp.done) begin
          hv_d = mu_rsp.res;
        end
      end
      default: begin
      end
    endcase

    if (cfg_we_i) begin
      fill_d    = '0;
      base_ok_d = 1'b0;
      if (cfg_idx_i == CFG_BASE) begin
        base_d = cfg_data_i;
      end else begin
        mod_d = (cfg_data_i < MOD_MIN) ? MOD_MIN : cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      base_q    <= BASE_RST;
      mod_q     <= MOD_RST;
      base_ok_q <= 1'b0;
      fill_q    <= '0;
      enc_q     <= '0;
    end else begin
      state_q   <= state_d;
      base_q    <= base_d;
      mod_q     <= mod_d;
      base_ok_q <= base_ok_d;
      fill_q    <= fill_d;
      enc_q     <= enc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    st_q        <= st_d;
    ch_q        <= ch_d;
    left_q      <= left_d;
    right_q     <= right_d;
    enc_start_q <= enc_start_d;
    base_red_q  <= base_red_d;
    hv_q        <= hv_d;
    hi_q        <= hi_d;
    pw_q        <= pw_d;
    pa_q        <= pa_d;
  end

  rhpt_modunit u_modunit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mu_req),
    .x_i    (mu_x),
    .y_i    (mu_y),
    .z_i    (mu_z),
    .mod_i  (mod_q),
    .rsp_o  (mu_rsp)
  );

  rhpt_ram #(
    .WIDTH (HW),
    .DEPTH (MAX_LEN)
  ) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (pre_we),
    .waddr_i (waddr),
    .wdata_i (pre_wdata),
    .re_i    (pre_re),
    .raddr_i (pre_raddr),
    .rdata_o (pre_rdata)
  );

  rhpt_ram #(
    .WIDTH (HW),
    .DEPTH (MAX_LEN)
  ) u_power_ram (
    .clk_i   (clk_i),
    .we_i    (pow_we),
    .waddr_i (waddr),
    .wdata_i (pow_wdata),
    .re_i    (pow_re),
    .raddr_i (pow_raddr),
    .rdata_o (pow_rdata)
  );

  assign busy            = (state_q != S_IDLE);
  assign done_o          = (state_q == S_OUT);
  assign hash_value_o    = hv_q;
  assign stored_length_o = fill_q;
  assign status_o        = st_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL)
    else $error("fill count beyond store depth");

  a_unit_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mu_rsp.done |-> (state_q == S_BASE_W || state_q == S_CRED_W || state_q == S_MUL_H ||
                     state_q == S_MUL_P || state_q == S_Q_MUL || state_q == S_Q_SUB))
    else $error("arithmetic unit finished with no state waiting on it");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (hash_value_o == '0))
    else $error("error result carries a non-zero hash");

  a_hash_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_OK) |-> (hash_value_o < mod_q))
    else $error("hash not reduced by the modulus");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import rhpt_pkg::*;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned LENW        = $clog2(DEPTH + 1);
  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct {
    op_e             op;
    logic [CHW-1:0]  ch;
    logic [IDXW-1:0] left;
    logic [IDXW-1:0] right;
    logic            restart;
    bit              drain;
  } hash_req_t;

  typedef struct {
    logic [HW-1:0]   hash;
    logic [LENW-1:0] len;
    status_e         status;
  } hash_res_t;

  logic            clk_i          = 1'b0;
  logic            rst_ni         = 1'b0;
  logic            start          = 1'b0;
  logic            busy;
  logic [1:0]      operation_i    = '0;
  logic [CHW-1:0]  char_value_i   = '0;
  logic [IDXW-1:0] left_index_i   = '0;
  logic [IDXW-1:0] right_index_i  = '0;
  logic            encode_start_i = 1'b0;
  logic            done_o;
  logic [HW-1:0]   hash_value_o;
  logic [LENW-1:0] stored_length_o;
  logic [1:0]      status_o;
  logic            cfg_we_i       = 1'b0;
  logic [0:0]      cfg_idx_i      = '0;
  logic [HW-1:0]   cfg_data_i     = '0;

  rolling_hash_prefix_table #(
    .MAX_LEN(DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .char_value_i   (char_value_i),
    .left_index_i   (left_index_i),
    .right_index_i  (right_index_i),
    .encode_start_i (encode_start_i),
    .done_o         (done_o),
    .hash_value_o   (hash_value_o),
    .stored_length_o(stored_length_o),
    .status_o       (status_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [HW-1:0] cur_base = BASE_RST;
  logic [HW-1:0] cur_mod  = MOD_RST;
  logic [HW-1:0] prefix_tbl [DEPTH];
  logic [HW-1:0] power_tbl  [DEPTH];
  int unsigned   fill_len   = 0;
  logic [HW-1:0] enc_acc    = '0;

  hash_req_t   req_q[$];
  hash_res_t   hash_expect_q[$];
  hash_req_t   cur_req;
  int unsigned gen_len      = 0;
  int unsigned pushed_total = 0;
  int unsigned acc_cnt      = 0;
  int unsigned done_cnt     = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_cnt    = 0;
  int unsigned n_err        = 0;
  int unsigned op_cnt [4]   = '{default: 0};
  int unsigned st_cnt [4]   = '{default: 0};

  function automatic logic [63:0] eff_mod();
    return (cur_mod < MOD_MIN) ? 64'(MOD_MIN) : 64'(cur_mod);
  endfunction

  function automatic logic [HW-1:0] mul_add(logic [HW-1:0] a, logic [HW-1:0] c);
    return HW'((64'(a) * 64'(cur_base) + 64'(c)) % eff_mod());
  endfunction

  function automatic logic [HW-1:0] prefix_upto(int unsigned k);
    return (k == 0) ? '0 : prefix_tbl[k-1];
  endfunction

  function automatic hash_res_t predict_hash(hash_req_t rq);
    hash_res_t     rs;
    logic [63:0]   m;
    logic [63:0]   hi;
    logic [63:0]   lo;
    int unsigned   span;
    logic [HW-1:0] prev_pow;
    rs.hash   = '0;
    rs.status = ST_OK;
    case (rq.op)
      OP_APPEND: begin
        if (fill_len >= DEPTH) begin
          rs.status = ST_FULL;
        end else begin
          prev_pow = (fill_len != 0) ? power_tbl[fill_len-1] : HW'(1);
          rs.hash = mul_add(prefix_upto(fill_len), HW'(rq.ch));
          prefix_tbl[fill_len] = rs.hash;
          power_tbl[fill_len]  = mul_add(prev_pow, '0);
          fill_len++;
        end
      end
      OP_REMOVE: begin
        if (fill_len == 0) begin
          rs.status = ST_EMPTY;
        end else begin
          fill_len--;
          rs.hash = prefix_upto(fill_len);
        end
      end
      OP_QUERY: begin
        if (rq.left > rq.right || rq.right >= fill_len) begin
          rs.status = ST_RANGE;
        end else begin
          m    = eff_mod();
          span = rq.right - rq.left + 1;
          hi   = 64'(prefix_upto(32'(rq.right) + 1)) % m;
          lo   = (64'(prefix_upto(rq.left)) * 64'(power_tbl[span-1])) % m;
          rs.hash = HW'((hi + m - lo) % m);
        end
      end
      default: begin
        if (rq.restart) enc_acc = '0;
        enc_acc = mul_add(enc_acc, HW'(rq.ch));
        rs.hash = enc_acc;
      end
    endcase
    rs.len = LENW'(fill_len);
    return rs;
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic fire;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        hash_expect_q = {hash_expect_q, predict_hash(cur_req)};
        op_cnt[cur_req.op]++;
        acc_cnt <= acc_cnt + 1;
      end
      if (start && !fire) begin
        // held until accepted
      end else if (req_q.size() != 0 && $urandom_range(99) >= idle_pct &&
                   !(req_q[0].drain && acc_cnt + fire != done_cnt)) begin
        cur_req = req_q.pop_front();
        operation_i    <= cur_req.op;
        char_value_i   <= cur_req.ch;
        left_index_i   <= cur_req.left;
        right_index_i  <= cur_req.right;
        encode_start_i <= cur_req.restart;
        start          <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    hash_res_t want;
    if (rst_ni && done_o) begin
      done_cnt <= done_cnt + 1;
      if (hash_expect_q.size() == 0) begin
        $error("unexpected result: hash_value %0d", hash_value_o);
        n_err++;
      end else begin
        want = hash_expect_q.pop_front();
        st_cnt[want.status]++;
        if (hash_value_o !== want.hash) begin
          $error("hash_value: expected %0d, got %0d", want.hash, hash_value_o);
          n_err++;
        end
        if (stored_length_o !== want.len) begin
          $error("stored_length: expected %0d, got %0d", want.len, stored_length_o);
          n_err++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
      $display("rolling_hash_prefix_table test failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic push_req(op_e op, int unsigned ch, int unsigned l, int unsigned r,
                          int unsigned restart, bit drain = 1'b0);
    hash_req_t rq;
    rq.op      = op;
    rq.ch      = CHW'(ch);
    rq.left    = IDXW'(l);
    rq.right   = IDXW'(r);
    rq.restart = restart[0];
    rq.drain   = drain;
    req_q = {req_q, rq};
    pushed_total++;
    if (op == OP_APPEND && gen_len < DEPTH) gen_len++;
    if (op == OP_REMOVE && gen_len != 0) gen_len--;
  endtask

  task automatic push_valid_query(bit drain);
    int unsigned r;
    r = $urandom_range(gen_len - 1);
    push_req(OP_QUERY, $urandom, $urandom_range(r), r, $urandom, drain);
  endtask

  task automatic rand_mix(int unsigned n);
    int unsigned roll;
    int unsigned pick;
    int unsigned r;
    bit          drain;
    repeat (n) begin
      roll  = $urandom_range(99);
      drain = ($urandom_range(99) == 0);
      if (roll < 40) begin
        push_req(OP_APPEND, $urandom, $urandom, $urandom, $urandom, drain);
      end else if (roll < 70) begin
        pick = $urandom_range(99);
        if (gen_len != 0 && pick < 70) begin
          push_valid_query(drain);
        end else if (pick < 85) begin
          r = (gen_len < DEPTH) ? gen_len : $urandom_range(DEPTH - 1);
          push_req(OP_QUERY, $urandom, $urandom_range(r), r, $urandom, drain);
        end else begin
          push_req(OP_QUERY, $urandom, $urandom, $urandom, $urandom, drain);
        end
      end else if (roll < 85) begin
        push_req(OP_REMOVE, $urandom, $urandom, $urandom, $urandom, drain);
      end else begin
        push_req(OP_ENCODE, $urandom, $urandom, $urandom,
                 ($urandom_range(3) == 0) ? 1 : 0, drain);
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (!(acc_cnt == pushed_total && done_cnt == pushed_total && !busy));
  endtask

  task automatic write_reg(cfg_e idx, logic [HW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == CFG_BASE) cur_base = val;
    else cur_mod = val;
    fill_len = 0;
    gen_len  = 0;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_hash_params(logic [HW-1:0] base, logic [HW-1:0] modulus);
    wait_drained();
    write_reg(CFG_BASE, base);
    write_reg(CFG_MOD, modulus);
    @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_pct = 22;
    push_req(OP_REMOVE, 0, 0, 0, 0);
    push_req(OP_QUERY, 0, 0, 0, 0);
    push_req(OP_ENCODE, 8'h00, 0, 0, 1);
    push_req(OP_ENCODE, 8'hFF, 0, 0, 0);
    push_req(OP_ENCODE, 8'h5A, 0, 0, 1);
    push_req(OP_APPEND, 8'h00, 0, 0, 0);
    push_req(OP_APPEND, 8'hFF, 0, 0, 0);
    push_req(OP_APPEND, 8'hA5, 0, 0, 0);
    push_req(OP_APPEND, 8'h5A, 0, 0, 0);
    push_req(OP_QUERY, 0, 0, 0, 0);
    push_req(OP_QUERY, 0, 0, 3, 0);
    push_req(OP_QUERY, 0, 3, 3, 0);
    push_req(OP_QUERY, 0, 2, 1, 0);
    push_req(OP_QUERY, 0, 1, 4, 0);
    push_req(OP_QUERY, 0, 1023, 1023, 1);
    push_req(OP_QUERY, 0, 0, 1023, 0);
    push_req(OP_REMOVE, 0, 0, 0, 0);
    push_req(OP_QUERY, 0, 0, 2, 0);
    push_req(OP_APPEND, 8'h01, 0, 0, 0, 1'b1);
    push_req(OP_ENCODE, 8'h33, 0, 0, 0, 1'b1);
    repeat (5) push_req(OP_REMOVE, 0, 0, 0, 0);
    rand_mix(250);

    // largest modulus, base one below it
    set_hash_params(31'd2147483646, 31'd2147483647);
    rand_mix(200);

    // fill the store to capacity, then work at the top end
    set_hash_params(31'd31, 31'd65521);
    idle_pct = 83;
    while (gen_len < DEPTH) begin
      if (gen_len != 0 && $urandom_range(9) == 0) push_valid_query(1'b0);
      else push_req(OP_APPEND, $urandom, $urandom, $urandom, $urandom);
    end
    repeat (3) push_req(OP_APPEND, $urandom, 0, 0, 0);
    push_req(OP_QUERY, 0, 0, 1023, 0);
    push_req(OP_QUERY, 0, 1023, 1023, 0);
    push_req(OP_QUERY, 0, 512, 1023, 0);
    push_req(OP_QUERY, 0, 0, 0, 0);
    push_req(OP_REMOVE, 0, 0, 0, 0);
    push_req(OP_QUERY, 0, 0, 1023, 0);
    rand_mix(60);

    // zero base, modulus below two
    set_hash_params(31'd0, 31'd0);
    rand_mix(60);

    idle_pct = 0;
    set_hash_params(31'd5, 31'd1);
    rand_mix(60);

    // base well above modulus
    set_hash_params(31'd2147483646, 31'd1000);
    rand_mix(100);

    set_hash_params(BASE_RST, MOD_RST);
    rand_mix(150);

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (hash_expect_q.size() != 0) begin
      $error("%0d results never arrived", hash_expect_q.size());
      n_err++;
    end
    $display("requests: %0d append, %0d remove, %0d query, %0d encode over 7 hash settings",
             op_cnt[OP_APPEND], op_cnt[OP_REMOVE], op_cnt[OP_QUERY], op_cnt[OP_ENCODE]);
    $display("results: %0d checked, %0d full, %0d empty, %0d bad range, %0d mismatches",
             done_cnt, st_cnt[ST_FULL], st_cnt[ST_EMPTY], st_cnt[ST_RANGE], n_err);
    if (n_err == 0) begin
      $display("rolling_hash_prefix_table test passed");
    end else begin
      $display("rolling_hash_prefix_table test failed");
    end
    $finish;
  end

endmodule
